// File: src/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int FIU_W      = 4;
    localparam int SLOT_OUT_W = 3;
    localparam int COUNT_W    = 32;

    localparam logic [FIU_W-1:0]   FIU_RESET = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_AGE    = 4'b1000
    } state_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic evict;
    } lrupr_res_t;

endpackage

// File: src/lrupr_page_mem.sv
// ----------------------------------------------------------------------------
// lrupr_page_mem
// Resident page store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lrupr_page_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/lrupr_scan.sv
// ----------------------------------------------------------------------------
// lrupr_scan
// Frame sequencer: serial lookup over the page store, victim choice and a
// serial ageing pass, one frame per cycle through a shared compare unit.
// ----------------------------------------------------------------------------
module lrupr_scan #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int SLOT_W    = 3,
    parameter int AGE_W     = 3,
    parameter int CNT_W     = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PAGE_BITS-1:0]  page,
    input  logic [CNT_W-1:0]      n_active,
    output logic                  busy,
    output lrupr_pkg::lrupr_res_t res,
    output logic [SLOT_W-1:0]     res_slot,
    output logic [PAGE_BITS-1:0]  res_ev_page
);

    import lrupr_pkg::*;

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(FRAMES - 1);

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [SLOT_W-1:0]     evi_reg, evi_next;
    logic                  pend_reg, pend_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [FRAMES-1:0]     valid_reg, valid_next;
    logic [AGE_W-1:0]      age_reg [FRAMES];
    logic [AGE_W-1:0]      age_wr;
    logic                  age_we;
    logic                  hitf_reg, hitf_next;
    logic [SLOT_W-1:0]     hits_reg, hits_next;
    logic [AGE_W-1:0]      hita_reg, hita_next;
    logic                  empf_reg, empf_next;
    logic [SLOT_W-1:0]     emps_reg, emps_next;
    logic [SLOT_W-1:0]     bests_reg, bests_next;
    logic [AGE_W-1:0]      besta_reg, besta_next;
    logic [PAGE_BITS-1:0]  bestp_reg, bestp_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [AGE_W-1:0]      old_reg, old_next;
    logic                  wasv_reg, wasv_next;
    logic                  evict_reg, evict_next;

    logic                  rd_en;
    logic [PAGE_BITS-1:0]  rd_data;
    logic                  wr_en;
    logic [SLOT_W-1:0]     dec_slot;
    logic [SLOT_W-1:0]     age_idx;
    logic [AGE_W-1:0]      age_cur;
    logic                  last_j;

    assign rd_en    = (state_reg == ST_SCAN) && (int'(idx_reg) < int'(n_active));
    assign wr_en    = (state_reg == ST_DECIDE) && !hitf_reg;
    assign dec_slot = hitf_reg ? hits_reg : (empf_reg ? emps_reg : bests_reg);
    assign age_idx  = (state_reg == ST_AGE) ? idx_reg : evi_reg;
    assign age_cur  = age_reg[age_idx];
    assign last_j   = (int'(idx_reg) == int'(n_active) - 1);

    lrupr_page_mem #(
        .DEPTH (FRAMES),
        .AW    (SLOT_W),
        .DW    (PAGE_BITS)
    ) u_page_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (dec_slot),
        .wr_data (page_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        evi_next   = evi_reg;
        pend_next  = 1'b0;
        page_next  = page_reg;
        valid_next = valid_reg;
        hitf_next  = hitf_reg;
        hits_next  = hits_reg;
        hita_next  = hita_reg;
        empf_next  = empf_reg;
        emps_next  = emps_reg;
        bests_next = bests_reg;
        besta_next = besta_reg;
        bestp_next = bestp_reg;
        slot_next  = slot_reg;
        old_next   = old_reg;
        wasv_next  = wasv_reg;
        evict_next = evict_reg;
        age_we     = 1'b0;
        age_wr     = age_cur;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    page_next  = page;
                    idx_next   = '0;
                    hitf_next  = 1'b0;
                    empf_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    evi_next  = idx_reg;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (!hitf_reg && valid_reg[evi_reg] && (rd_data == page_reg))
                    begin
                        hitf_next = 1'b1;
                        hits_next = evi_reg;
                        hita_next = age_cur;
                    end
                    if (!empf_reg && !valid_reg[evi_reg])
                    begin
                        empf_next = 1'b1;
                        emps_next = evi_reg;
                    end
                    if ((evi_reg == '0) || (age_cur > besta_reg))
                    begin
                        bests_next = evi_reg;
                        besta_next = age_cur;
                        bestp_next = rd_data;
                    end
                    if (int'(evi_reg) == int'(n_active) - 1)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                slot_next  = dec_slot;
                wasv_next  = hitf_reg || !empf_reg;
                old_next   = hitf_reg ? hita_reg : besta_reg;
                evict_next = !hitf_reg && !empf_reg;
                valid_next[dec_slot] = 1'b1;
                idx_next   = '0;
                state_next = ST_AGE;
            end
            ST_AGE:
            begin
                age_we = 1'b1;
                if (idx_reg == slot_reg)
                begin
                    age_wr = '0;
                end
                else if (valid_reg[idx_reg] && (!wasv_reg || (age_cur < old_reg))
                         && (age_cur < AGE_MAX))
                begin
                    age_wr = age_cur + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (last_j)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            valid_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
            if (age_we)
            begin
                age_reg[idx_reg] <= age_wr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        evi_reg   <= evi_next;
        page_reg  <= page_next;
        hitf_reg  <= hitf_next;
        hits_reg  <= hits_next;
        hita_reg  <= hita_next;
        empf_reg  <= empf_next;
        emps_reg  <= emps_next;
        bests_reg <= bests_next;
        besta_reg <= besta_next;
        bestp_reg <= bestp_next;
        slot_reg  <= slot_next;
        old_reg   <= old_next;
        wasv_reg  <= wasv_next;
        evict_reg <= evict_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign res.done    = (state_reg == ST_AGE) && last_j;
    assign res.hit     = hitf_reg;
    assign res.evict   = evict_reg;
    assign res_slot    = slot_reg;
    assign res_ev_page = bestp_reg;

endmodule

// File: src/lru_page_replacement.sv
// An accepted request passes through a scan state, which streams the page store
// past the compare unit one frame per cycle over the n active frames (frames_in_use
// clamped to 1..FRAMES), a decide state that picks the slot and writes the page on
// a miss, and an ageing pass over the frames. The result is registered and
// follows in the cycle after the ageing pass ends, with done high for a single
// cycle; it must be taken then, as there is no back-pressure. start may be raised
// again as soon as busy drops. Write frames_in_use through cfg_wr_en/cfg_wr_data
// only while the unit is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement unit: lookup, fault handling, victim choice, counts.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [PAGE_BITS-1:0]             page,
    output logic                             busy,
    input  logic                             cfg_wr_en,
    input  logic [lrupr_pkg::FIU_W-1:0]      cfg_wr_data,
    output logic                             done,
    output logic                             hit,
    output logic [lrupr_pkg::SLOT_OUT_W-1:0] slot,
    output logic                             evicted_valid,
    output logic [PAGE_BITS-1:0]             evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0]    fault_count,
    output logic [lrupr_pkg::COUNT_W-1:0]    reference_count
);

    import lrupr_pkg::*;

    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int AGE_W  = SLOT_W;
    localparam int CNT_W  = $clog2(FRAMES + 1);

    logic [FIU_W-1:0]     fiu_reg;
    logic [CNT_W-1:0]     n_active;
    lrupr_res_t           res;
    logic [SLOT_W-1:0]    res_slot;
    logic [PAGE_BITS-1:0] res_ev_page;

    logic [COUNT_W-1:0]   ref_total_reg, ref_total_next;
    logic [COUNT_W-1:0]   fault_total_reg, fault_total_next;
    logic                 done_reg;
    logic                 hit_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 evv_reg;
    logic [PAGE_BITS-1:0] evp_reg;

    always_comb
    begin
        if (fiu_reg == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (int'(fiu_reg) > FRAMES)
        begin
            n_active = CNT_W'(FRAMES);
        end
        else
        begin
            n_active = CNT_W'(fiu_reg);
        end
    end

    lrupr_scan #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .SLOT_W    (SLOT_W),
        .AGE_W     (AGE_W),
        .CNT_W     (CNT_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .page        (page),
        .n_active    (n_active),
        .busy        (busy),
        .res         (res),
        .res_slot    (res_slot),
        .res_ev_page (res_ev_page)
    );

    // saturating running counts
    assign ref_total_next   = (ref_total_reg == COUNT_MAX) ? ref_total_reg
                                                           : ref_total_reg + 1'b1;
    assign fault_total_next = (res.hit || (fault_total_reg == COUNT_MAX)) ? fault_total_reg
                                                           : fault_total_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg         <= FIU_RESET;
            ref_total_reg   <= '0;
            fault_total_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fiu_reg <= cfg_wr_data;
            end
            done_reg <= res.done;
            if (res.done)
            begin
                ref_total_reg   <= ref_total_next;
                fault_total_reg <= fault_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            hit_reg  <= res.hit;
            slot_reg <= res_slot;
            evv_reg  <= res.evict;
            evp_reg  <= res.evict ? res_ev_page : '0;
        end
    end

    assign done            = done_reg;
    assign hit             = hit_reg;
    assign slot            = SLOT_OUT_W'(slot_reg);
    assign evicted_valid   = evv_reg;
    assign evicted_page    = evp_reg;
    assign fault_count     = fault_total_reg;
    assign reference_count = ref_total_reg;

endmodule

// File: dv/lru_page_replacement_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_page_replacement_test
// Self-checking bench for the LRU page replacement unit. A fixed table of
// requests and frame-count writes runs first, followed by random page streams.
// Each stream mixes a small working set with stray pages and all-zero/all-one
// pages, under a range of frame counts and sender gap rates. Every result is
// compared field by field with a local model of the replacement table, or with
// the literal outcome where a table row gives one.
module lru_page_replacement_test;

    import lrupr_pkg::*;

    localparam int FRAMES            = FRAMES_DEF;
    localparam int PAGE_W            = PAGE_BITS_DEF;
    localparam int AGE_W             = $clog2(FRAMES);
    localparam int AGE_MAX           = FRAMES - 1;
    localparam int SEGMENTS          = 12;
    localparam int ITEMS_PER_SEGMENT = 80;
    localparam int DRAIN_CYCLES      = 2 * FRAMES + 6;
    localparam int CYCLE_LIMIT       = 400000;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted_valid;
        logic [PAGE_W-1:0]     evicted_page;
        logic [COUNT_W-1:0]    fault_count;
        logic [COUNT_W-1:0]    reference_count;
    } page_outcome_t;

    typedef enum logic {
        ROW_REF,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [PAGE_W-1:0] value;
        logic              literal;
        page_outcome_t     lit;
    } stim_row_t;

    // literal rows: reset state and the first fills, readable straight off
    localparam stim_row_t DIRECTED [24] = '{
        '{ROW_REF, 16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1, 32'd1}},
        '{ROW_REF, 16'hFFFF, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd2, 32'd2}},
        '{ROW_REF, 16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd2, 32'd3}},
        '{ROW_REF, 16'h0003, 1'b1, '{1'b0, 3'd2, 1'b0, 16'h0000, 32'd3, 32'd4}},
        '{ROW_REF, 16'h5555, 1'b1, '{1'b0, 3'd3, 1'b0, 16'h0000, 32'd4, 32'd5}},
        '{ROW_REF, 16'hAAAA, 1'b1, '{1'b0, 3'd4, 1'b0, 16'h0000, 32'd5, 32'd6}},
        '{ROW_REF, 16'h0007, 1'b0, '0},
        '{ROW_REF, 16'h0008, 1'b0, '0},
        '{ROW_REF, 16'h8001, 1'b0, '0},
        '{ROW_REF, 16'h1234, 1'b0, '0},
        '{ROW_REF, 16'hFFFF, 1'b0, '0},
        '{ROW_REF, 16'h0003, 1'b0, '0},
        '{ROW_CFG, 16'h0000, 1'b0, '0},
        '{ROW_REF, 16'h0000, 1'b0, '0},
        '{ROW_REF, 16'h7FFF, 1'b0, '0},
        '{ROW_CFG, 16'h000F, 1'b0, '0},
        '{ROW_REF, 16'h5555, 1'b0, '0},
        '{ROW_REF, 16'h0001, 1'b0, '0},
        '{ROW_CFG, 16'h0002, 1'b0, '0},
        '{ROW_REF, 16'h0000, 1'b0, '0},
        '{ROW_REF, 16'h00FF, 1'b0, '0},
        '{ROW_REF, 16'h0000, 1'b0, '0},
        '{ROW_CFG, 16'h0008, 1'b0, '0},
        '{ROW_REF, 16'h1234, 1'b0, '0}
    };

    localparam logic [FIU_W-1:0] CFG_EXTREMES [4] = '{4'd1, 4'd8, 4'd0, 4'd15};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic [PAGE_W-1:0]     page;
    logic                  busy;
    logic                  cfg_wr_en;
    logic [FIU_W-1:0]      cfg_wr_data;
    logic                  done;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted_valid;
    logic [PAGE_W-1:0]     evicted_page;
    logic [COUNT_W-1:0]    fault_count;
    logic [COUNT_W-1:0]    reference_count;

    // model of the frame table
    logic [PAGE_W-1:0]  table_page  [FRAMES];
    logic               table_valid [FRAMES];
    logic [AGE_W-1:0]   table_age   [FRAMES];
    logic [COUNT_W-1:0] faults_model;
    logic [COUNT_W-1:0] refs_model;
    logic [FIU_W-1:0]   frames_setting;

    page_outcome_t pending_outcomes [$];

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned requests_sent  = 0;
    int unsigned hits_seen      = 0;
    int unsigned evictions_seen = 0;
    int unsigned cfg_writes     = 0;

    lru_page_replacement #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_W)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .page            (page),
        .busy            (busy),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .done            (done),
        .hit             (hit),
        .slot            (slot),
        .evicted_valid   (evicted_valid),
        .evicted_page    (evicted_page),
        .fault_count     (fault_count),
        .reference_count (reference_count)
    );

    always #5 clk = ~clk;

    function automatic int active_span();
        int n;
        n = int'(frames_setting);
        if (n < 1)
            n = 1;
        if (n > FRAMES)
            n = FRAMES;
        return n;
    endfunction

    // used frame: age 0; valid active frames younger (all if it was free) age up
    function automatic void make_most_recent(int s, int n, bit was_valid);
        logic [AGE_W-1:0] old_age;
        old_age = table_age[s];
        for (int i = 0; i < n; i++)
        begin
            if (i != s && table_valid[i] && (!was_valid || table_age[i] < old_age)
                && table_age[i] < AGE_MAX)
                table_age[i]++;
        end
        table_age[s] = '0;
    endfunction

    function automatic page_outcome_t predict_reference(logic [PAGE_W-1:0] pg);
        page_outcome_t r;
        int            n;
        int            s;
        bit            found;
        bit            was_valid;
        r     = '0;
        n     = active_span();
        s     = 0;
        found = 1'b0;
        if (refs_model != COUNT_MAX)
            refs_model++;
        for (int i = 0; i < n; i++)
        begin
            if (!found && table_valid[i] && table_page[i] == pg)
            begin
                found = 1'b1;
                s     = i;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            make_most_recent(s, n, 1'b1);
        end
        else
        begin
            if (faults_model != COUNT_MAX)
                faults_model++;
            for (int i = 0; i < n; i++)
            begin
                if (!found && !table_valid[i])
                begin
                    found = 1'b1;
                    s     = i;
                end
            end
            if (!found)
            begin
                s = 0;
                for (int i = 1; i < n; i++)
                begin
                    if (table_age[i] > table_age[s])
                        s = i;
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = table_page[s];
            end
            was_valid      = table_valid[s];
            table_page[s]  = pg;
            table_valid[s] = 1'b1;
            make_most_recent(s, n, was_valid);
        end
        r.slot            = s[SLOT_OUT_W-1:0];
        r.fault_count     = faults_model;
        r.reference_count = refs_model;
        return r;
    endfunction

    task automatic flag_field(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch, %s: expected %h, got %h", $realtime, what, want_v, got_v);
    endtask

    // send one request; start stays high on return
    task automatic issue_reference(input logic [PAGE_W-1:0] pg, input logic use_literal,
                                   input page_outcome_t literal_outcome);
        page_outcome_t predicted;
        start <= 1'b1;
        page  <= pg;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predicted = predict_reference(pg);
        pending_outcomes.push_back(use_literal ? literal_outcome : predicted);
        requests_sent++;
    endtask

    task automatic wait_until_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic write_frames_in_use(input logic [FIU_W-1:0] v);
        wait_until_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        frames_setting = v;
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    always @(posedge clk)
    begin : result_check
        page_outcome_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
                flag_field("result with no request outstanding", '0, '0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (hit !== want.hit)
                    flag_field("hit", 32'(want.hit), 32'(hit));
                if (slot !== want.slot)
                    flag_field("slot", 32'(want.slot), 32'(slot));
                if (evicted_valid !== want.evicted_valid)
                    flag_field("evicted_valid", 32'(want.evicted_valid), 32'(evicted_valid));
                if (evicted_page !== want.evicted_page)
                    flag_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page));
                if (fault_count !== want.fault_count)
                    flag_field("fault_count", want.fault_count, fault_count);
                if (reference_count !== want.reference_count)
                    flag_field("reference_count", want.reference_count, reference_count);
                if (want.hit)
                    hits_seen++;
                if (want.evicted_valid)
                    evictions_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("lru_page_replacement regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [PAGE_W-1:0] pool [12];
        logic [PAGE_W-1:0] pg;
        int                pool_len;
        int                idle_pct;
        rst_n       = 1'b0;
        start       = 1'b0;
        page        = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            table_page[i]  = '0;
            table_valid[i] = 1'b0;
            table_age[i]   = '0;
        end
        faults_model   = '0;
        refs_model     = '0;
        frames_setting = FIU_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].kind == ROW_CFG)
                write_frames_in_use(DIRECTED[r].value[FIU_W-1:0]);
            else
                issue_reference(DIRECTED[r].value, DIRECTED[r].literal, DIRECTED[r].lit);
        end

        // sender gaps: light, then heavy, then back to back
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            idle_pct = (seg < 4) ? 6 : ((seg < 8) ? 61 : 0);
            write_frames_in_use((seg < 4) ? CFG_EXTREMES[seg] : FIU_W'($urandom_range(15)));
            pool_len = $urandom_range(1, active_span() + 4);
            foreach (pool[i])
                pool[i] = PAGE_W'($urandom);
            repeat (ITEMS_PER_SEGMENT)
            begin
                case ($urandom_range(19))
                    0:       pg = '0;
                    1:       pg = '1;
                    2, 3, 4: pg = PAGE_W'($urandom);
                    default: pg = pool[$urandom_range(pool_len - 1)];
                endcase
                if ($urandom_range(99) < idle_pct)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 2 * FRAMES + 8)) @(posedge clk);
                end
                issue_reference(pg, 1'b0, '0);
            end
        end

        wait_until_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d page requests: %0d hits, %0d evictions, %0d frame-count writes",
                 requests_sent, hits_seen, evictions_seen, cfg_writes);
        $display("field mismatches: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("lru_page_replacement regression: pass");
        else
            $display("lru_page_replacement regression: fail");
        $finish;
    end

endmodule
